### sv/bfr_pkg.sv
// ----------------------------------------------------------------------------
// bfr_pkg
// shared constants, codes and types for the ordered job queue
// ----------------------------------------------------------------------------
package bfr_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_W     = 16;
  localparam int HANDLE_W = 16;
  localparam int MODE_W   = 2;
  localparam int CAP_W    = 5;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OCC_W    = 5;

  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REM = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // command broadcast to every cell
  typedef struct packed {
    logic    shift_all;
    logic    remove;
    id_t     key;
    handle_t handle;
  } bfr_cmd_t;

endpackage

### sv/bounded_fifo_remove_by_id_top.sv
// ----------------------------------------------------------------------------
// bounded_fifo_remove_by_id_top
// ordered job queue with enqueue, dequeue and remove by identifier
// ----------------------------------------------------------------------------
// The input stream carries one request per word: in_tuser holds the mode
// (enqueue, dequeue head, remove by identifier, no-op), in_tdata the job id
// and handle. Every request gives exactly one result word on the output
// stream: out_tuser is the success flag, out_tdata the taken id and handle
// plus occupancy, full and empty after the request.
// Entries sit in a row of DEPTH cells, head in cell 0. Each cell compares
// its id with the key and a found chain runs along the row, so a remove
// closes its gap and a dequeue shifts the whole row in the same cycle.
// A request is done in the cycle it is accepted; its result appears in the
// output register in the cycle after. One word per cycle is sustained while
// the receiver takes each result; the single output register sets this figure.
// While the receiver stalls the result is held and in_tready drops until it
// is taken. cfg_wdata sets the capacity (saturated at DEPTH).
// Reset empties the queue, clears the output valid and sets capacity to 16.
// ----------------------------------------------------------------------------
module bounded_fifo_remove_by_id_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [4:0]  cfg_wdata,   // capacity
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // job_id, job_handle
  input  logic [1:0]  in_tuser,    // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // out_id, out_handle, occupancy, full_flag,
                                   // empty_flag, zero pad
  output logic [0:0]  out_tuser    // op_ok
);
  import bfr_pkg::*;

  logic [CAP_W-1:0] cap_r;
  cnt_t             count_r;
  cnt_t             count_nxt;
  cnt_t             eff_cap;
  logic             out_valid_r;
  logic [39:0]      out_data_r;
  logic [39:0]      out_data_nxt;
  logic             out_ok_r;
  logic             out_ok_nxt;

  bfr_cmd_t         cmd;
  logic             accept;
  logic [MODE_W-1:0] mode;
  logic             enq_ok;
  logic             any_found;
  logic             head_take;
  logic             op_ok;
  id_t              res_id;
  handle_t          res_handle;
  id_t              hit_id;
  handle_t          hit_handle;

  id_t              cell_id     [DEPTH];
  handle_t          cell_handle [DEPTH];
  logic             cell_match  [DEPTH];
  logic             cell_hit    [DEPTH];
  logic [DEPTH:0]   found;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign mode      = in_tuser;

  assign eff_cap   = (cap_r > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
  assign enq_ok    = (count_r < eff_cap);
  assign any_found = found[DEPTH];

  always_comb begin
    head_take = 1'b0;
    case (mode)
      MODE_DEQ: head_take = (count_r != '0);
      MODE_REM: head_take = !any_found && cell_match[0];
      default:  head_take = 1'b0;
    endcase
  end

  assign cmd.shift_all = accept && head_take;
  assign cmd.remove    = accept && (mode == MODE_REM);
  assign cmd.key       = in_tdata[ID_W-1:0];
  assign cmd.handle    = in_tdata[ID_W+HANDLE_W-1:ID_W];

  assign found[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      id_t     nb_id;
      handle_t nb_handle;
      logic    load;
      logic    occ;

      if (gi == DEPTH - 1) begin : g_last
        assign nb_id     = '0;
        assign nb_handle = '0;
      end else begin : g_mid
        assign nb_id     = cell_id[gi+1];
        assign nb_handle = cell_handle[gi+1];
      end

      assign occ  = (count_r > CNT_W'(gi));
      assign load = accept && (mode == MODE_ENQ) && enq_ok && (count_r == CNT_W'(gi));

      bfr_cell u_cell (
        .clk       (clk),
        .cmd       (cmd),
        .load      (load),
        .occ       (occ),
        .is_head   (gi == 0),
        .nb_id     (nb_id),
        .nb_handle (nb_handle),
        .found_in  (found[gi]),
        .found_out (found[gi+1]),
        .match     (cell_match[gi]),
        .hit       (cell_hit[gi]),
        .id_q      (cell_id[gi]),
        .handle_q  (cell_handle[gi])
      );
    end
  endgenerate

  always_comb begin
    hit_id     = '0;
    hit_handle = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_id     = hit_id     | (cell_id[i]     & {ID_W{cell_hit[i]}});
      hit_handle = hit_handle | (cell_handle[i] & {HANDLE_W{cell_hit[i]}});
    end
  end

  always_comb begin
    op_ok      = 1'b0;
    res_id     = '0;
    res_handle = '0;
    count_nxt  = count_r;
    case (mode)
      MODE_ENQ: begin
        if (enq_ok) begin
          op_ok     = 1'b1;
          count_nxt = count_r + cnt_t'(1);
        end
      end
      MODE_DEQ, MODE_REM: begin
        if (mode == MODE_REM && any_found) begin
          op_ok      = 1'b1;
          res_id     = hit_id;
          res_handle = hit_handle;
          count_nxt  = count_r - cnt_t'(1);
        end else if (head_take) begin
          op_ok      = 1'b1;
          res_id     = cell_id[0];
          res_handle = cell_handle[0];
          count_nxt  = count_r - cnt_t'(1);
        end
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_ok_nxt   = op_ok;
    out_data_nxt = '0;
    out_data_nxt[ID_W-1:0]                      = res_id;
    out_data_nxt[ID_W+HANDLE_W-1:ID_W]          = res_handle;
    out_data_nxt[36:32]                         = OCC_W'(count_nxt);
    out_data_nxt[37]                            = (count_nxt >= eff_cap);
    out_data_nxt[38]                            = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_W'(16);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        cap_r <= cfg_wdata;
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
      out_ok_r   <= out_ok_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_ok_r;

endmodule

### sv/bfr_cell.sv
// ----------------------------------------------------------------------------
// bfr_cell
// one queue slot: holds an entry, compares it with the key, passes the
// match chain on and takes its right neighbor's entry when the gap closes
// ----------------------------------------------------------------------------
module bfr_cell (
  input  logic              clk,
  input  bfr_pkg::bfr_cmd_t cmd,
  input  logic              load,
  input  logic              occ,
  input  logic              is_head,
  input  bfr_pkg::id_t      nb_id,
  input  bfr_pkg::handle_t  nb_handle,
  input  logic              found_in,
  output logic              found_out,
  output logic              match,
  output logic              hit,
  output bfr_pkg::id_t      id_q,
  output bfr_pkg::handle_t  handle_q
);
  import bfr_pkg::*;

  id_t     id_r;
  id_t     id_nxt;
  handle_t handle_r;
  handle_t handle_nxt;
  logic    shift;

  assign match     = occ && (id_r == cmd.key);
  assign hit       = match && !is_head && !found_in;
  assign found_out = found_in || (match && !is_head);
  assign shift     = cmd.shift_all || (cmd.remove && found_out);

  always_comb begin
    id_nxt     = id_r;
    handle_nxt = handle_r;
    if (load) begin
      id_nxt     = cmd.key;
      handle_nxt = cmd.handle;
    end else if (shift) begin
      id_nxt     = nb_id;
      handle_nxt = nb_handle;
    end
  end

  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    handle_r <= handle_nxt;
  end

  assign id_q     = id_r;
  assign handle_q = handle_r;

endmodule

### tb/bounded_fifo_remove_by_id_top_tb.sv
// ----------------------------------------------------------------------------
// bounded_fifo_remove_by_id_top_tb
// self-checking bench for the ordered job queue with remove by identifier
// ----------------------------------------------------------------------------
// A queue-fed driver offers request words on the input stream with random
// gaps, and a receiver takes result words with random stalls. A monitor keeps
// a shadow of the job row and capacity. It predicts one result per accepted
// request and checks each result word against the oldest prediction. A
// directed opening covers empty and full cases, no-op words, duplicate ids at
// head and tail, and capacity at zero, one, saturated and below the fill
// level. Random phases follow, across many capacity settings. They include
// long receiver holds that back the block up, and pauses until all results
// have drained.
// ----------------------------------------------------------------------------
module bounded_fifo_remove_by_id_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_GAP     = 12;
  localparam int PHASE_ITEMS = 70;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    id_t               id;
    handle_t           handle;
  } job_req_t;

  typedef struct packed {
    logic             ok;
    id_t              id;
    handle_t          handle;
    logic [OCC_W-1:0] occ;
    logic             full;
    logic             empty;
  } job_res_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             cfg_wen    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata  = '0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata   = '0;   // job_id, job_handle
  logic [1:0]       in_tuser   = '0;   // mode
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [39:0]      out_tdata;         // out_id, out_handle, occupancy, full, empty, pad
  logic [0:0]       out_tuser;         // op_ok

  bounded_fifo_remove_by_id_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // shadow job row
  id_t              row_ids [DEPTH];
  handle_t          row_handles [DEPTH];
  int               row_count   = 0;
  logic [CAP_W-1:0] cap_setting = 5'd16;

  job_req_t request_q [$];
  job_res_t expected_results [$];

  int   submitted_cnt = 0;
  int   results_seen  = 0;
  int   mismatch_cnt  = 0;
  int   ok_cnt        = 0;
  int   remove_hits   = 0;
  int   enq_refused   = 0;
  int   cap_writes    = 0;
  int   cycle_cnt     = 0;
  logic in_hs         = 1'b0;
  logic out_hs        = 1'b0;
  logic rx_block      = 1'b0;
  event long_hold_ev;

  function automatic void drop_entry(input int pos);
    int k;
    for (k = pos; k < row_count - 1; k++) begin
      row_ids[k]     = row_ids[k + 1];
      row_handles[k] = row_handles[k + 1];
    end
    row_count--;
  endfunction

  function automatic job_res_t apply_request(input job_req_t rq);
    job_res_t r;
    int       cap;
    int       hit;
    int       i;
    bit       found;
    r     = '0;
    cap   = (cap_setting > DEPTH) ? DEPTH : int'(cap_setting);
    hit   = 0;
    found = 1'b0;
    case (rq.mode)
      MODE_ENQ: begin
        if (row_count < cap) begin
          row_ids[row_count]     = rq.id;
          row_handles[row_count] = rq.handle;
          row_count++;
          r.ok = 1'b1;
        end
      end
      MODE_DEQ: begin
        if (row_count > 0) begin
          r.ok     = 1'b1;
          r.id     = row_ids[0];
          r.handle = row_handles[0];
          drop_entry(0);
        end
      end
      MODE_REM: begin
        // earliest match behind the head wins, head only as a last resort
        for (i = 1; i < row_count; i++) begin
          if (!found && row_ids[i] == rq.id) begin
            hit   = i;
            found = 1'b1;
          end
        end
        if (!found && row_count > 0 && row_ids[0] == rq.id) begin
          found = 1'b1;
        end
        if (found) begin
          r.ok     = 1'b1;
          r.id     = row_ids[hit];
          r.handle = row_handles[hit];
          drop_entry(hit);
        end
      end
      default: begin
      end
    endcase
    r.occ   = row_count[OCC_W-1:0];
    r.full  = (row_count >= cap);
    r.empty = (row_count == 0);
    return r;
  endfunction

  // request driver
  int tx_gap   = 0;
  bit tx_burst = 1'b0;
  always @(negedge clk) begin
    job_req_t rq;
    logic     vld;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      vld = in_tvalid && !in_hs;
      if (!vld) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (request_q.size() > 0) begin
          rq = request_q.pop_front();
          in_tuser <= rq.mode;
          in_tdata <= {rq.handle, rq.id};
          vld = 1'b1;
          if ($urandom_range(0, 19) == 0) tx_burst = ~tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
      end
      in_tvalid <= vld;
    end
  end

  // result receiver
  int rx_gap   = 0;
  bit rx_burst = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_hs) begin
        if ($urandom_range(0, 19) == 0) rx_burst = ~rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !rx_block;
      end
    end
  end

  // long receiver hold
  initial begin
    forever begin
      @(long_hold_ev);
      rx_block <= 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
      rx_block <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    job_req_t rq;
    job_res_t got;
    job_res_t want;
    if (!rst_n) begin
      row_count   = 0;
      cap_setting = 5'd16;
      in_hs  <= 1'b0;
      out_hs <= 1'b0;
    end else begin
      in_hs  <= in_tvalid && in_tready;
      out_hs <= out_tvalid && out_tready;
      if (cfg_wen) begin
        cap_setting = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.ok     = out_tuser[0];
        got.id     = out_tdata[15:0];
        got.handle = out_tdata[31:16];
        got.occ    = out_tdata[36:32];
        got.full   = out_tdata[37];
        got.empty  = out_tdata[38];
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("[%0t] result word with nothing expected: ok=%0b id=%h handle=%h",
                     $realtime, got.ok, got.id, got.handle);
          end
        end else begin
          want = expected_results.pop_front();
          if (got.ok !== want.ok || got.id !== want.id || got.handle !== want.handle ||
              got.occ !== want.occ || got.full !== want.full || got.empty !== want.empty) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("[%0t] mismatch expected ok=%0b id=%h handle=%h occ=%0d full=%0b empty=%0b",
                       $realtime, want.ok, want.id, want.handle, want.occ, want.full,
                       want.empty);
              $display("[%0t]          actual   ok=%0b id=%h handle=%h occ=%0d full=%0b empty=%0b",
                       $realtime, got.ok, got.id, got.handle, got.occ, got.full, got.empty);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        rq.mode   = in_tuser;
        rq.id     = in_tdata[15:0];
        rq.handle = in_tdata[31:16];
        want = apply_request(rq);
        expected_results.push_back(want);
        if (want.ok) ok_cnt++;
        if (want.ok && rq.mode == MODE_REM) remove_hits++;
        if (!want.ok && rq.mode == MODE_ENQ) enq_refused++;
      end
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d of %0d results seen",
             cycle_cnt, results_seen, submitted_cnt);
    $display("bounded_fifo_remove_by_id_top verification failed");
    $finish;
  end

  task automatic push_req(input logic [MODE_W-1:0] mode, input id_t id, input handle_t h);
    job_req_t rq;
    rq.mode   = mode;
    rq.id     = id;
    rq.handle = h;
    request_q.push_back(rq);
    submitted_cnt++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (results_seen != submitted_cnt);
    @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    cap_writes++;
    @(posedge clk);
  endtask

  task automatic push_random(input int bias, input id_t pool [6]);
    int          r;
    logic [MODE_W-1:0] mode;
    id_t         id;
    r = $urandom_range(0, 99);
    case (bias)
      0:       mode = (r < 65) ? MODE_ENQ : (r < 80) ? MODE_DEQ : (r < 96) ? MODE_REM : MODE_NOP;
      1:       mode = (r < 25) ? MODE_ENQ : (r < 55) ? MODE_DEQ : (r < 95) ? MODE_REM : MODE_NOP;
      default: mode = (r < 45) ? MODE_ENQ : (r < 65) ? MODE_DEQ : (r < 95) ? MODE_REM : MODE_NOP;
    endcase
    id = ($urandom_range(0, 3) == 0) ? id_t'($urandom) : pool[$urandom_range(0, 5)];
    push_req(mode, id, handle_t'($urandom));
  endtask

  initial begin
    logic [CAP_W-1:0] caps [12];
    id_t              pool [6];
    int               p;
    int               n;
    int               bias;
    caps = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd8, 5'd2, 5'd17, 5'd12, 5'd16, 5'd0, 5'd0};
    caps[10] = CAP_W'($urandom_range(0, 31));
    caps[11] = CAP_W'($urandom_range(1, 16));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_capacity(5'd16);

    // empty queue, no-op, duplicate ids at head and tail
    push_req(MODE_DEQ, 16'h0000, 16'h0000);
    push_req(MODE_REM, 16'h0000, 16'h0000);
    push_req(MODE_NOP, 16'hFFFF, 16'hFFFF);
    push_req(MODE_ENQ, 16'h0000, 16'h0000);
    push_req(MODE_ENQ, 16'hFFFF, 16'hFFFF);
    push_req(MODE_ENQ, 16'h0005, 16'h0001);
    push_req(MODE_ENQ, 16'h0005, 16'h0002);
    push_req(MODE_ENQ, 16'h0005, 16'h0003);
    push_req(MODE_REM, 16'h0005, 16'h0000);
    push_req(MODE_REM, 16'h0000, 16'h0000);
    push_req(MODE_REM, 16'h7777, 16'h0000);
    push_req(MODE_ENQ, 16'hFFFF, 16'h0009);
    push_req(MODE_REM, 16'hFFFF, 16'h0000);
    push_req(MODE_REM, 16'h0005, 16'h0000);
    push_req(MODE_REM, 16'h0005, 16'h0000);
    push_req(MODE_NOP, 16'h0000, 16'h0000);
    push_req(MODE_DEQ, 16'h0000, 16'h0000);
    push_req(MODE_DEQ, 16'h0000, 16'h0000);
    wait_idle();

    // capacity one and zero
    set_capacity(5'd1);
    push_req(MODE_ENQ, 16'hA5A5, 16'h5A5A);
    push_req(MODE_ENQ, 16'h1111, 16'h2222);
    push_req(MODE_REM, 16'hA5A5, 16'h0000);
    wait_idle();
    set_capacity(5'd0);
    push_req(MODE_ENQ, 16'h3333, 16'h4444);
    push_req(MODE_NOP, 16'h0000, 16'h0000);
    wait_idle();

    // saturated capacity, then lowered below the fill level
    set_capacity(5'd31);
    for (n = 0; n <= DEPTH; n++) begin
      push_req(MODE_ENQ, id_t'($urandom), handle_t'($urandom));
    end
    wait_idle();
    set_capacity(5'd3);
    push_req(MODE_ENQ, 16'h5555, 16'h6666);
    push_req(MODE_DEQ, 16'h0000, 16'h0000);
    push_req(MODE_ENQ, 16'h5555, 16'h6666);
    wait_idle();

    for (p = 0; p < 12; p++) begin
      set_capacity(caps[p]);
      pool[0] = 16'h0000;
      pool[1] = 16'hFFFF;
      for (n = 2; n < 6; n++) pool[n] = id_t'($urandom);
      bias = (p == 0 || p == 6) ? 0 : $urandom_range(0, 2);
      for (n = 0; n < PHASE_ITEMS / 2; n++) begin
        push_random(bias, pool);
      end
      if (p == 0 || p == 6) begin
        -> long_hold_ev;
      end
      if (p % 2 == 1) begin
        wait_idle();
      end
      bias = $urandom_range(0, 2);
      for (n = PHASE_ITEMS / 2; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) bias = $urandom_range(0, 2);
        push_random(bias, pool);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("run covered %0d requests under %0d capacity writes", submitted_cnt, cap_writes);
    $display("%0d succeeded, %0d removes hit, %0d enqueues refused, %0d mismatches",
             ok_cnt, remove_hits, enq_refused, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("bounded_fifo_remove_by_id_top verification clean");
    end else begin
      $display("bounded_fifo_remove_by_id_top verification failed");
    end
    $finish;
  end

endmodule
